@@ rtl/core/mmhm_pkg.sv @@
// ----------------------------------------------------------------------------
// Min/max hold meter package
// Shared widths, view codes, limit constants and the idle timer control beat.
// ----------------------------------------------------------------------------
package mmhm_pkg;

   // Default parameter values.
   localparam int SAMPLE_BITS_DEF    = 12;
   localparam int TICKS_PER_UNIT_DEF = 3;

   // Fixed field widths of the result channel.
   localparam int OUT_W   = 12;
   localparam int VIEW_W  = 3;
   localparam int LIMIT_W = 7;

   // View codes.
   localparam logic [VIEW_W-1:0] VIEW_ACTUAL = 3'd0;
   localparam logic [VIEW_W-1:0] VIEW_HIGH   = 3'd1;
   localparam logic [VIEW_W-1:0] VIEW_LOW    = 3'd2;
   localparam logic [VIEW_W-1:0] VIEW_TIME   = 3'd3;
   localparam logic [VIEW_W-1:0] VIEW_POWER  = 3'd4;

   // Inactivity limit constants.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd60;
   localparam logic [LIMIT_W-1:0] LIMIT_STEP  = 7'd10;
   localparam logic [LIMIT_W:0]   LIMIT_WRAP  = 8'd130;
   localparam int                 LIMIT_MAX   = 120;

   // Control beat from the view logic to the idle timer.
   typedef struct packed {
      logic advance;   // an item was accepted this cycle
      logic clear;     // a button was pressed this tick
      logic step;      // action press in the time view
   } idle_ctl_type;

endpackage

@@ rtl/core/mmhm_idle_timer.sv @@
// ----------------------------------------------------------------------------
// Min/max hold meter idle timer
// Holds the inactivity limit and the tick counter, and flags a timeout.
// ----------------------------------------------------------------------------
module mmhm_idle_timer
   import mmhm_pkg::*;
#(
   parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  idle_ctl_type       ctl,
   output logic [LIMIT_W-1:0] limit_in,
   output logic               timeout
);

   // The counter never passes the largest limit times the unit, plus one.
   localparam int TICK_W = $clog2(LIMIT_MAX * TICKS_PER_UNIT + 2);
   localparam logic [TICK_W-1:0] TPU_K = TICK_W'(TICKS_PER_UNIT);

   logic [LIMIT_W-1:0] limit_ff;
   logic [TICK_W-1:0]  ticks_ff;
   logic [TICK_W-1:0]  ticks_in;
   logic [TICK_W-1:0]  ticks_base;
   logic [TICK_W-1:0]  ticks_inc;
   logic [TICK_W-1:0]  threshold;
   logic [LIMIT_W:0]   limit_sum;

   // Step the limit by ten, wrapping back to ten at the top.
   always_comb begin
      limit_sum = {1'b0, limit_ff} + {1'b0, LIMIT_STEP};
      if (!ctl.step) begin
         limit_in = limit_ff;
      end else if (limit_sum >= LIMIT_WRAP) begin
         limit_in = LIMIT_STEP;
      end else begin
         limit_in = limit_sum[LIMIT_W-1:0];
      end
   end

   // Count the tick and compare against the scaled limit.
   always_comb begin
      ticks_base = ctl.clear ? '0 : ticks_ff;
      ticks_inc  = ticks_base + TICK_W'(1);
      threshold  = TPU_K * TICK_W'(limit_in);
      timeout    = (ticks_inc > threshold);
      ticks_in   = timeout ? '0 : ticks_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         ticks_ff <= '0;
      end else if (ctl.advance) begin
         limit_ff <= limit_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

@@ rtl/core/min_max_hold_meter_control.sv @@
// ----------------------------------------------------------------------------
// Min/max hold meter control
// One tick per input beat: view selection, extreme hold and idle power-off.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one tick: a sample and the two button events.
// The rsp_ channel returns exactly one result beat per tick: the view, the
// value shown in it, the held maximum and minimum, and a power-off request.
// All state is updated in the cycle a req_ beat is accepted, and the result
// sits in the output register from the next cycle. Throughput is one tick
// per cycle; the only limit is the single output register, which takes a
// new beat whenever it is empty or being drained. When the receiver stalls,
// req_ready falls until the waiting result is taken. Reset puts the view on
// actual, the limit at 60, clears the idle counter and empties the output
// register; the first tick after reset loads both extremes with its sample.
// ----------------------------------------------------------------------------
module min_max_hold_meter_control
   import mmhm_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_mode_press,
   input  logic                   req_action_press,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VIEW_W-1:0]      rsp_view,
   output logic [OUT_W-1:0]       rsp_shown_value,
   output logic [OUT_W-1:0]       rsp_peak_value,
   output logic [OUT_W-1:0]       rsp_valley_value,
   output logic                   rsp_power_off
);

   logic                   accept;
   logic [VIEW_W-1:0]      view_ff;
   logic [VIEW_W-1:0]      view_in;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [SAMPLE_BITS-1:0] max_in;
   logic [SAMPLE_BITS-1:0] max_base;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] min_in;
   logic [SAMPLE_BITS-1:0] min_base;
   logic                   primed_ff;
   logic                   manual_off;
   logic [OUT_W-1:0]       shown;
   logic [LIMIT_W-1:0]     limit_in;
   logic                   timeout;
   idle_ctl_type           idle_ctl;

   logic                   rsp_valid_ff;
   logic [VIEW_W-1:0]      rsp_view_ff;
   logic [OUT_W-1:0]       rsp_shown_ff;
   logic [OUT_W-1:0]       rsp_peak_ff;
   logic [OUT_W-1:0]       rsp_valley_ff;
   logic                   rsp_off_ff;

   // Take a new beat whenever the output register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Advance the view; codes past on/off return to actual.
   always_comb begin
      if (!req_mode_press) begin
         view_in = view_ff;
      end else if (view_ff >= VIEW_POWER) begin
         view_in = VIEW_ACTUAL;
      end else begin
         view_in = view_ff + VIEW_W'(1);
      end
   end

   // Prime, apply the action reset, track the sample and flag a manual power-off.
   always_comb begin
      max_base = primed_ff ? max_ff : req_sample;
      min_base = primed_ff ? min_ff : req_sample;
      if (req_action_press && view_in == VIEW_HIGH) begin
         max_base = req_sample;
      end
      if (req_action_press && view_in == VIEW_LOW) begin
         min_base = req_sample;
      end
      max_in     = (req_sample > max_base) ? req_sample : max_base;
      min_in     = (req_sample < min_base) ? req_sample : min_base;
      manual_off = req_action_press && (view_in >= VIEW_POWER);
   end

   // Control beat for the idle timer.
   always_comb begin
      idle_ctl.advance = accept;
      idle_ctl.clear   = req_mode_press || req_action_press;
      idle_ctl.step    = req_action_press && (view_in == VIEW_TIME);
   end

   mmhm_idle_timer #(
      .TICKS_PER_UNIT(TICKS_PER_UNIT)
   ) u_idle_timer (
      .clock   (clock),
      .reset   (reset),
      .ctl     (idle_ctl),
      .limit_in(limit_in),
      .timeout (timeout)
   );

   // Select the value for the current view.
   always_comb begin
      case (view_in)
         VIEW_ACTUAL: shown = OUT_W'(req_sample);
         VIEW_HIGH:   shown = OUT_W'(max_in);
         VIEW_LOW:    shown = OUT_W'(min_in);
         VIEW_TIME:   shown = OUT_W'(limit_in);
         default:     shown = '0;
      endcase
   end

   // Meter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff   <= VIEW_ACTUAL;
         primed_ff <= 1'b0;
         max_ff    <= '0;
         min_ff    <= '0;
      end else if (accept) begin
         view_ff   <= view_in;
         primed_ff <= 1'b1;
         max_ff    <= max_in;
         min_ff    <= min_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_view_ff   <= view_in;
         rsp_shown_ff  <= shown;
         rsp_peak_ff   <= OUT_W'(max_in);
         rsp_valley_ff <= OUT_W'(min_in);
         rsp_off_ff    <= manual_off || timeout;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_view         = rsp_view_ff;
   assign rsp_shown_value  = rsp_shown_ff;
   assign rsp_peak_value   = rsp_peak_ff;
   assign rsp_valley_value = rsp_valley_ff;
   assign rsp_power_off    = rsp_off_ff;

endmodule
